FILE: rtl/prifov_pkg.sv
// Package for the point range / intensity / field-of-view filter.
// Holds default widths, register indexes and the control structs shared by the filter modules.
// No dependencies.
package prifov_pkg;

    localparam int COORD_WIDTH_DEF     = 24;
    localparam int INTENSITY_WIDTH_DEF = 16;

    // Cosine register: signed Q1.15
    localparam int COS_WIDTH   = 16;
    // Squared cosine magnitude reaches 2^30, so it needs one bit more than 30
    localparam int COS_SQ_WIDTH = 2 * COS_WIDTH - 1;
    // Scale of the squared cosine: (2^15)^2
    localparam int AZ_SHIFT    = 2 * (COS_WIDTH - 1);

    localparam int CFG_IDX_WIDTH = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_RANGE_MIN      = 3'd0,
        REG_RANGE_MAX      = 3'd1,
        REG_INTENSITY_LOW  = 3'd2,
        REG_INTENSITY_HIGH = 3'd3,
        REG_FOV_ENABLE     = 3'd4,
        REG_HALF_FOV_COS   = 3'd5
    } t_cfg_idx;

    // Per-point flags that travel with the data through the pipeline
    typedef struct packed {
        logic last;
        logic finite;
        logic int_ok;
        logic x_neg;
        logic origin;
    } t_pt_flags;

    // Azimuth window controls
    typedef struct packed {
        logic enable;
        logic cos_neg;
    } t_fov_cfg;

endpackage

FILE: rtl/prifov_in_if.sv
// Input point channel: valid/ready handshake plus the point payload.
// Depends on prifov_pkg for default widths.
interface prifov_in_if #(
    parameter int COORD_WIDTH     = prifov_pkg::COORD_WIDTH_DEF,
    parameter int INTENSITY_WIDTH = prifov_pkg::INTENSITY_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_WIDTH-1:0]     px;
    logic signed [COORD_WIDTH-1:0]     py;
    logic signed [COORD_WIDTH-1:0]     pz;
    logic        [INTENSITY_WIDTH-1:0] intensity;
    logic                              finite;
    logic                              last_in;

    modport source (
        output valid, px, py, pz, intensity, finite, last_in,
        input  ready
    );
    modport sink (
        input  valid, px, py, pz, intensity, finite, last_in,
        output ready
    );
endinterface

FILE: rtl/prifov_out_if.sv
// Result channel: valid/ready handshake plus the point and its keep bit.
// Depends on prifov_pkg for default widths.
interface prifov_out_if #(
    parameter int COORD_WIDTH     = prifov_pkg::COORD_WIDTH_DEF,
    parameter int INTENSITY_WIDTH = prifov_pkg::INTENSITY_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_WIDTH-1:0]     qx;
    logic signed [COORD_WIDTH-1:0]     qy;
    logic signed [COORD_WIDTH-1:0]     qz;
    logic        [INTENSITY_WIDTH-1:0] q_intensity;
    logic                              keep;
    logic                              last_out;

    modport source (
        output valid, qx, qy, qz, q_intensity, keep, last_out,
        input  ready
    );
    modport sink (
        input  valid, qx, qy, qz, q_intensity, keep, last_out,
        output ready
    );
endinterface

FILE: rtl/point_range_intensity_fov_filter_core.sv
// Top level of the point range / intensity / field-of-view filter.
// Depends on prifov_pkg, prifov_in_if, prifov_out_if, prifov_cfg_regs, prifov_front, prifov_back.
//
//  port        | direction | handshake          | payload
//  ------------+-----------+--------------------+------------------------------------------
//  i_pt        | in        | valid / ready      | px, py, pz, intensity, finite, last_in
//  o_pt        | out       | valid / ready      | qx, qy, qz, q_intensity, keep, last_out
//  i_cfg_*     | in        | write enable only  | register index, write data
//
// One point per clock is accepted and one result per clock leaves while the output is not
// stalled; points pass through five register stages (magnitude, square, sum, range test and
// split product, azimuth compare into the output register).
// Reset is synchronous and active low; it clears the stage valid bits and loads the
// register defaults (full range, full intensity band, azimuth window off, cosine -1.0).
// Each stage holds while the stage after it is full and stalled; bubbles are squeezed out,
// so a stalled output does not stop points entering until every stage is occupied.
// Configuration writes reach the squared thresholds through one more register than the other
// settings; write them only while no point is in flight.
module point_range_intensity_fov_filter_core #(
    parameter int COORD_WIDTH     = prifov_pkg::COORD_WIDTH_DEF,
    parameter int INTENSITY_WIDTH = prifov_pkg::INTENSITY_WIDTH_DEF,
    localparam int CfgDataWidth0  = (COORD_WIDTH > INTENSITY_WIDTH) ? COORD_WIDTH
                                                                     : INTENSITY_WIDTH,
    localparam int CfgDataWidth   = (CfgDataWidth0 > prifov_pkg::COS_WIDTH) ? CfgDataWidth0
                                                                           : prifov_pkg::COS_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    prifov_in_if.sink                            i_pt,
    prifov_out_if.source                         o_pt,
    input  logic                                 i_cfg_we,
    input  logic [prifov_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CfgDataWidth-1:0]              i_cfg_data
);
    import prifov_pkg::*;

    localparam int SqW = 2 * COORD_WIDTH;

    // Configuration outputs
    logic [SqW-1:0]             rmin2, rmax2;
    logic [INTENSITY_WIDTH-1:0] int_low, int_high;
    logic [COS_SQ_WIDTH-1:0]    ac2;
    t_fov_cfg                   fov;

    // Front to back transfer
    logic                              mid_valid, mid_ready;
    logic signed [COORD_WIDTH-1:0]     mid_px, mid_py, mid_pz;
    logic        [INTENSITY_WIDTH-1:0] mid_int;
    t_pt_flags                         mid_flags;
    logic        [SqW-1:0]             mid_x2;
    logic        [SqW:0]               mid_rxy2;
    logic        [SqW+1:0]             mid_r2;

    prifov_cfg_regs #(
        .COORD_WIDTH     (COORD_WIDTH),
        .INTENSITY_WIDTH (INTENSITY_WIDTH),
        .CFG_DATA_WIDTH  (CfgDataWidth)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rmin2    (rmin2),
        .o_rmax2    (rmax2),
        .o_int_low  (int_low),
        .o_int_high (int_high),
        .o_ac2      (ac2),
        .o_fov      (fov)
    );

    // Magnitudes, squares and sums; intensity band tested on entry
    prifov_front #(
        .COORD_WIDTH     (COORD_WIDTH),
        .INTENSITY_WIDTH (INTENSITY_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pt.valid),
        .o_ready     (i_pt.ready),
        .i_px        (i_pt.px),
        .i_py        (i_pt.py),
        .i_pz        (i_pt.pz),
        .i_intensity (i_pt.intensity),
        .i_finite    (i_pt.finite),
        .i_last      (i_pt.last_in),
        .i_int_low   (int_low),
        .i_int_high  (int_high),
        .o_valid     (mid_valid),
        .i_ready     (mid_ready),
        .o_px        (mid_px),
        .o_py        (mid_py),
        .o_pz        (mid_pz),
        .o_intensity (mid_int),
        .o_flags     (mid_flags),
        .o_x2        (mid_x2),
        .o_rxy2      (mid_rxy2),
        .o_r2        (mid_r2)
    );

    // Range window, azimuth window and keep decision; drives the output register
    prifov_back #(
        .COORD_WIDTH     (COORD_WIDTH),
        .INTENSITY_WIDTH (INTENSITY_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mid_valid),
        .o_ready       (mid_ready),
        .i_px          (mid_px),
        .i_py          (mid_py),
        .i_pz          (mid_pz),
        .i_intensity   (mid_int),
        .i_flags       (mid_flags),
        .i_x2          (mid_x2),
        .i_rxy2        (mid_rxy2),
        .i_r2          (mid_r2),
        .i_rmin2       (rmin2),
        .i_rmax2       (rmax2),
        .i_ac2         (ac2),
        .i_fov         (fov),
        .o_valid       (o_pt.valid),
        .i_ready       (o_pt.ready),
        .o_qx          (o_pt.qx),
        .o_qy          (o_pt.qy),
        .o_qz          (o_pt.qz),
        .o_q_intensity (o_pt.q_intensity),
        .o_keep        (o_pt.keep),
        .o_last        (o_pt.last_out)
    );

endmodule

FILE: rtl/prifov_cfg_regs.sv
// Configuration registers of the filter and the squared thresholds derived from them.
// Depends on prifov_pkg.
module prifov_cfg_regs #(
    parameter int COORD_WIDTH     = prifov_pkg::COORD_WIDTH_DEF,
    parameter int INTENSITY_WIDTH = prifov_pkg::INTENSITY_WIDTH_DEF,
    parameter int CFG_DATA_WIDTH  = prifov_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [prifov_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0]            i_cfg_data,
    output logic [2*COORD_WIDTH-1:0]             o_rmin2,
    output logic [2*COORD_WIDTH-1:0]             o_rmax2,
    output logic [INTENSITY_WIDTH-1:0]           o_int_low,
    output logic [INTENSITY_WIDTH-1:0]           o_int_high,
    output logic [prifov_pkg::COS_SQ_WIDTH-1:0]  o_ac2,
    output prifov_pkg::t_fov_cfg                 o_fov
);
    import prifov_pkg::*;

    localparam int SqW = 2 * COORD_WIDTH;

    logic [COORD_WIDTH-1:0]     r_range_min;
    logic [COORD_WIDTH-1:0]     r_range_max;
    logic [INTENSITY_WIDTH-1:0] r_int_low;
    logic [INTENSITY_WIDTH-1:0] r_int_high;
    logic                       r_fov_en;
    logic [COS_WIDTH-1:0]       r_cos;
    logic [SqW-1:0]             r_rmin2;
    logic [SqW-1:0]             r_rmax2;
    logic [COS_SQ_WIDTH-1:0]    r_ac2;
    logic [COS_WIDTH-1:0]       cos_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= '0;
            r_range_max <= '1;
            r_int_low   <= '0;
            r_int_high  <= '1;
            r_fov_en    <= 1'b0;
            r_cos       <= {1'b1, {(COS_WIDTH-1){1'b0}}};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_RANGE_MIN:      r_range_min <= i_cfg_data[COORD_WIDTH-1:0];
                REG_RANGE_MAX:      r_range_max <= i_cfg_data[COORD_WIDTH-1:0];
                REG_INTENSITY_LOW:  r_int_low   <= i_cfg_data[INTENSITY_WIDTH-1:0];
                REG_INTENSITY_HIGH: r_int_high  <= i_cfg_data[INTENSITY_WIDTH-1:0];
                REG_FOV_ENABLE:     r_fov_en    <= i_cfg_data[0];
                REG_HALF_FOV_COS:   r_cos       <= i_cfg_data[COS_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Magnitude of the cosine; -1.0 maps to 2^15, which still fits unsigned
    assign cos_mag = r_cos[COS_WIDTH-1] ? (~r_cos + COS_WIDTH'(1)) : r_cos;

    // Squares are registered from the configuration registers, long before a point needs them
    always_ff @(posedge i_clk) begin
        r_rmin2 <= SqW'(r_range_min) * SqW'(r_range_min);
        r_rmax2 <= SqW'(r_range_max) * SqW'(r_range_max);
        r_ac2   <= COS_SQ_WIDTH'(cos_mag) * COS_SQ_WIDTH'(cos_mag);
    end

    assign o_rmin2        = r_rmin2;
    assign o_rmax2        = r_rmax2;
    assign o_int_low      = r_int_low;
    assign o_int_high     = r_int_high;
    assign o_ac2          = r_ac2;
    assign o_fov.enable   = r_fov_en;
    assign o_fov.cos_neg  = r_cos[COS_WIDTH-1];

    a_rst_range_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_range_max == '1 && r_fov_en == 1'b0))
        else $error("range_max or fov_enable not at reset value after reset");

endmodule

FILE: rtl/prifov_front.sv
// Front half of the filter pipeline: magnitudes, squares and the squared-range sums.
// Three register stages with per-stage valid; depends on prifov_pkg.
module prifov_front #(
    parameter int COORD_WIDTH     = prifov_pkg::COORD_WIDTH_DEF,
    parameter int INTENSITY_WIDTH = prifov_pkg::INTENSITY_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [COORD_WIDTH-1:0]     i_px,
    input  logic signed [COORD_WIDTH-1:0]     i_py,
    input  logic signed [COORD_WIDTH-1:0]     i_pz,
    input  logic        [INTENSITY_WIDTH-1:0] i_intensity,
    input  logic                              i_finite,
    input  logic                              i_last,
    input  logic        [INTENSITY_WIDTH-1:0] i_int_low,
    input  logic        [INTENSITY_WIDTH-1:0] i_int_high,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [COORD_WIDTH-1:0]     o_px,
    output logic signed [COORD_WIDTH-1:0]     o_py,
    output logic signed [COORD_WIDTH-1:0]     o_pz,
    output logic        [INTENSITY_WIDTH-1:0] o_intensity,
    output prifov_pkg::t_pt_flags             o_flags,
    output logic        [2*COORD_WIDTH-1:0]   o_x2,
    output logic        [2*COORD_WIDTH:0]     o_rxy2,
    output logic        [2*COORD_WIDTH+1:0]   o_r2
);
    import prifov_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int SqW = 2 * COORD_WIDTH;

    logic s1_rdy, s2_rdy, s3_rdy;
    logic [W-1:0] n_ax, n_ay, n_az;
    t_pt_flags    n_flags;

    // Stage 1: magnitudes and flags
    logic                       r_v1;
    logic signed [W-1:0]        r_px1, r_py1, r_pz1;
    logic [INTENSITY_WIDTH-1:0] r_int1;
    t_pt_flags                  r_flags1;
    logic [W-1:0]               r_ax1, r_ay1, r_az1;

    // Stage 2: squares
    logic                       r_v2;
    logic signed [W-1:0]        r_px2, r_py2, r_pz2;
    logic [INTENSITY_WIDTH-1:0] r_int2;
    t_pt_flags                  r_flags2;
    logic [SqW-1:0]             r_x2_2, r_y2_2, r_z2_2;

    // Stage 3: sums
    logic                       r_v3;
    logic signed [W-1:0]        r_px3, r_py3, r_pz3;
    logic [INTENSITY_WIDTH-1:0] r_int3;
    t_pt_flags                  r_flags3;
    logic [SqW-1:0]             r_x2_3;
    logic [SqW:0]               r_rxy2_3;
    logic [SqW+1:0]             r_r2_3;

    assign s3_rdy  = !r_v3 || i_ready;
    assign s2_rdy  = !r_v2 || s3_rdy;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_ready = s1_rdy;

    assign n_ax = i_px[W-1] ? (~W'(i_px) + W'(1)) : W'(i_px);
    assign n_ay = i_py[W-1] ? (~W'(i_py) + W'(1)) : W'(i_py);
    assign n_az = i_pz[W-1] ? (~W'(i_pz) + W'(1)) : W'(i_pz);

    always_comb begin
        n_flags.last   = i_last;
        n_flags.finite = i_finite;
        n_flags.int_ok = (i_intensity >= i_int_low) && (i_intensity <= i_int_high);
        n_flags.x_neg  = i_px[W-1];
        n_flags.origin = (i_px == '0) && (i_py == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_v1 <= i_valid;
            end
            if (s2_rdy) begin
                r_v2 <= r_v1;
            end
            if (s3_rdy) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_px1    <= i_px;
            r_py1    <= i_py;
            r_pz1    <= i_pz;
            r_int1   <= i_intensity;
            r_flags1 <= n_flags;
            r_ax1    <= n_ax;
            r_ay1    <= n_ay;
            r_az1    <= n_az;
        end
        if (s2_rdy) begin
            r_px2    <= r_px1;
            r_py2    <= r_py1;
            r_pz2    <= r_pz1;
            r_int2   <= r_int1;
            r_flags2 <= r_flags1;
            r_x2_2   <= SqW'(r_ax1) * SqW'(r_ax1);
            r_y2_2   <= SqW'(r_ay1) * SqW'(r_ay1);
            r_z2_2   <= SqW'(r_az1) * SqW'(r_az1);
        end
        if (s3_rdy) begin
            r_px3    <= r_px2;
            r_py3    <= r_py2;
            r_pz3    <= r_pz2;
            r_int3   <= r_int2;
            r_flags3 <= r_flags2;
            r_x2_3   <= r_x2_2;
            r_rxy2_3 <= (SqW+1)'(r_x2_2) + (SqW+1)'(r_y2_2);
            r_r2_3   <= (SqW+2)'(r_x2_2) + (SqW+2)'(r_y2_2) + (SqW+2)'(r_z2_2);
        end
    end

    assign o_valid     = r_v3;
    assign o_px        = r_px3;
    assign o_py        = r_py3;
    assign o_pz        = r_pz3;
    assign o_intensity = r_int3;
    assign o_flags     = r_flags3;
    assign o_x2        = r_x2_3;
    assign o_rxy2      = r_rxy2_3;
    assign o_r2        = r_r2_3;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !s2_rdy) |=> (r_v1 && $stable(r_px1) && $stable(r_ax1)))
        else $error("stage 1 lost or changed a stalled point");

    a_s3_sum_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((SqW+2)'(r_rxy2_3) <= r_r2_3 && (SqW+1)'(r_x2_3) <= r_rxy2_3))
        else $error("partial squared range exceeds full squared range");

endmodule

FILE: rtl/prifov_back.sv
// Back half of the filter pipeline: range compare, azimuth products and the keep decision.
// Two register stages, the last one is the output register; depends on prifov_pkg.
module prifov_back #(
    parameter int COORD_WIDTH     = prifov_pkg::COORD_WIDTH_DEF,
    parameter int INTENSITY_WIDTH = prifov_pkg::INTENSITY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_px,
    input  logic signed [COORD_WIDTH-1:0]       i_py,
    input  logic signed [COORD_WIDTH-1:0]       i_pz,
    input  logic        [INTENSITY_WIDTH-1:0]   i_intensity,
    input  prifov_pkg::t_pt_flags               i_flags,
    input  logic        [2*COORD_WIDTH-1:0]     i_x2,
    input  logic        [2*COORD_WIDTH:0]       i_rxy2,
    input  logic        [2*COORD_WIDTH+1:0]     i_r2,
    input  logic        [2*COORD_WIDTH-1:0]     i_rmin2,
    input  logic        [2*COORD_WIDTH-1:0]     i_rmax2,
    input  logic [prifov_pkg::COS_SQ_WIDTH-1:0] i_ac2,
    input  prifov_pkg::t_fov_cfg                i_fov,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_WIDTH-1:0]       o_qx,
    output logic signed [COORD_WIDTH-1:0]       o_qy,
    output logic signed [COORD_WIDTH-1:0]       o_qz,
    output logic        [INTENSITY_WIDTH-1:0]   o_q_intensity,
    output logic                                o_keep,
    output logic                                o_last
);
    import prifov_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int SqW   = 2 * COORD_WIDTH;
    localparam int LoPpW = W + COS_SQ_WIDTH;
    localparam int HiPpW = W + 1 + COS_SQ_WIDTH;
    localparam int ProdW = SqW + 1 + COS_SQ_WIDTH;

    logic s4_rdy, s5_rdy;

    // Stage 4: range test and split product of squared xy range by squared cosine
    logic                       r_v4;
    logic signed [W-1:0]        r_px4, r_py4, r_pz4;
    logic [INTENSITY_WIDTH-1:0] r_int4;
    t_pt_flags                  r_flags4;
    logic                       r_range_ok4;
    logic [SqW-1:0]             r_x2_4;
    logic [LoPpW-1:0]           r_pp_lo4;
    logic [HiPpW-1:0]           r_pp_hi4;

    // Stage 5: output register
    logic                       r_v5;
    logic signed [W-1:0]        r_px5, r_py5, r_pz5;
    logic [INTENSITY_WIDTH-1:0] r_int5;
    logic                       r_keep5;
    logic                       r_last5;

    logic [ProdW-1:0] lhs, rhs;
    logic             az_gt, az_lt, az_ok, n_keep;

    assign s5_rdy  = !r_v5 || i_ready;
    assign s4_rdy  = !r_v4 || s5_rdy;
    assign o_ready = s4_rdy;

    // x^2 * 2^30 against cos^2 * (x^2 + y^2), both exact
    assign lhs   = ProdW'(r_x2_4) << AZ_SHIFT;
    assign rhs   = (ProdW'(r_pp_hi4) << W) + ProdW'(r_pp_lo4);
    assign az_gt = lhs > rhs;
    assign az_lt = lhs < rhs;

    always_comb begin
        if (!i_fov.enable || r_flags4.origin) begin
            az_ok = 1'b1;
        end else if (!r_flags4.x_neg && i_fov.cos_neg) begin
            az_ok = 1'b1;
        end else if (r_flags4.x_neg && !i_fov.cos_neg) begin
            az_ok = 1'b0;
        end else if (!r_flags4.x_neg) begin
            az_ok = az_gt;
        end else begin
            az_ok = az_lt;
        end
        n_keep = az_ok && r_range_ok4 && r_flags4.int_ok && r_flags4.finite;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s4_rdy) begin
                r_v4 <= i_valid;
            end
            if (s5_rdy) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r_px4       <= i_px;
            r_py4       <= i_py;
            r_pz4       <= i_pz;
            r_int4      <= i_intensity;
            r_flags4    <= i_flags;
            r_range_ok4 <= (i_r2 >= (SqW+2)'(i_rmin2)) && (i_r2 <= (SqW+2)'(i_rmax2));
            r_x2_4      <= i_x2;
            r_pp_lo4    <= LoPpW'(i_rxy2[W-1:0]) * LoPpW'(i_ac2);
            r_pp_hi4    <= HiPpW'(i_rxy2[SqW:W]) * HiPpW'(i_ac2);
        end
        if (s5_rdy) begin
            r_px5   <= r_px4;
            r_py5   <= r_py4;
            r_pz5   <= r_pz4;
            r_int5  <= r_int4;
            r_keep5 <= n_keep;
            r_last5 <= r_flags4.last;
        end
    end

    assign o_valid       = r_v5;
    assign o_qx          = r_px5;
    assign o_qy          = r_py5;
    assign o_qz          = r_pz5;
    assign o_q_intensity = r_int5;
    assign o_keep        = r_keep5;
    assign o_last        = r_last5;

    a_s4_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !s5_rdy) |=> (r_v4 && $stable(r_pp_lo4) && $stable(r_flags4)))
        else $error("stage 4 lost or changed a stalled point");

    a_wrong_half_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && s5_rdy && i_fov.enable && r_flags4.x_neg && !i_fov.cos_neg) |=> !r_keep5)
        else $error("point behind a narrow window was kept");

    a_not_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && s5_rdy && !r_flags4.finite) |=> !r_keep5)
        else $error("non-finite point was kept");

endmodule

FILE: bench/point_range_intensity_fov_filter_core_tb.sv
// Self-checking bench for the point range / intensity / field-of-view filter core.
// Depends on prifov_pkg, prifov_in_if, prifov_out_if and the core; predicts every keep bit
// on its own and checks each filtered point in order under random stalls on both channels.
module point_range_intensity_fov_filter_core_tb;

    import prifov_pkg::*;

    localparam int CW         = COORD_WIDTH_DEF;
    localparam int IW         = INTENSITY_WIDTH_DEF;
    localparam int CFG_DW     = (CW > IW) ? CW : IW;
    localparam int PIPE_DEPTH = 5;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    // Indexes past the last register: writes to them must change nothing
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [IW-1:0]        inten;
        logic                 fin;
        logic                 last;
    } t_point;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [IW-1:0]        inten;
        logic                 keep;
        logic                 last;
    } t_filtered;

    typedef struct {
        logic [CW-1:0]               rmin;
        logic [CW-1:0]               rmax;
        logic [IW-1:0]               ilow;
        logic [IW-1:0]               ihigh;
        logic                        fov_en;
        logic signed [COS_WIDTH-1:0] cosq;
    } t_filter_cfg;

    logic i_clk;
    logic i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CFG_DW-1:0]        i_cfg_data;

    prifov_in_if  pt_in ();
    prifov_out_if pt_out ();

    point_range_intensity_fov_filter_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_in),
        .o_pt       (pt_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Bench copy of the filter registers, updated on every write
    t_filter_cfg filter_cfg;
    // Filtered points predicted for transfers already made, oldest first
    t_filtered   filtered_due[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;
    // Extra hold-off cycles for the result side, picked up after its next transfer
    int  rx_hold_req    = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    //------------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------------

    // Azimuth window on squares: compare x^2 * 2^30 against cq^2 * (x^2 + y^2),
    // settling the sign cases first so that no root is needed
    function automatic bit azimuth_passes(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        longint          sx, sy, sc;
        longint unsigned ax, ay, ac, x2, r2;
        logic [79:0]     lhs, rhs;
        sx = longint'(x);
        sy = longint'(y);
        sc = longint'(filter_cfg.cosq);
        // the origin always lies in the window
        if (sx == 0 && sy == 0) return 1'b1;
        if (sx >= 0 && sc < 0)  return 1'b1;
        if (sx < 0 && sc >= 0)  return 1'b0;
        ax  = (sx < 0) ? -sx : sx;
        ay  = (sy < 0) ? -sy : sy;
        ac  = (sc < 0) ? -sc : sc;
        x2  = ax * ax;
        r2  = x2 + ay * ay;
        lhs = 80'(x2) << AZ_SHIFT;
        rhs = 80'(r2) * 80'(ac * ac);
        return (sx >= 0) ? (lhs > rhs) : (lhs < rhs);
    endfunction

    function automatic t_filtered predict_filtered_point(t_point p);
        t_filtered       r;
        longint          sx, sy, sz;
        longint unsigned r2, lo2, hi2;
        sx  = longint'(p.x);
        sy  = longint'(p.y);
        sz  = longint'(p.z);
        r2  = sx * sx + sy * sy + sz * sz;
        lo2 = 64'(filter_cfg.rmin);
        lo2 = lo2 * lo2;
        hi2 = 64'(filter_cfg.rmax);
        hi2 = hi2 * hi2;
        r.x     = p.x;
        r.y     = p.y;
        r.z     = p.z;
        r.inten = p.inten;
        r.last  = p.last;
        r.keep  = 1'b1;
        if (r2 < lo2 || r2 > hi2) r.keep = 1'b0;
        if (p.inten < filter_cfg.ilow || p.inten > filter_cfg.ihigh) r.keep = 1'b0;
        if (filter_cfg.fov_en && !azimuth_passes(p.x, p.y)) r.keep = 1'b0;
        if (!p.fin) r.keep = 1'b0;
        return r;
    endfunction

    //------------------------------------------------------------------------
    // Configuration
    //------------------------------------------------------------------------

    function automatic t_filter_cfg reset_filter_cfg();
        t_filter_cfg c;
        c.rmin   = '0;
        c.rmax   = '1;
        c.ilow   = '0;
        c.ihigh  = '1;
        c.fov_en = 1'b0;
        c.cosq   = {1'b1, {(COS_WIDTH-1){1'b0}}};
        return c;
    endfunction

    // Drive one write and mirror it; leaves the write enable high for the caller to drop
    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_RANGE_MIN:      filter_cfg.rmin   = data[CW-1:0];
            REG_RANGE_MAX:      filter_cfg.rmax   = data[CW-1:0];
            REG_INTENSITY_LOW:  filter_cfg.ilow   = data[IW-1:0];
            REG_INTENSITY_HIGH: filter_cfg.ihigh  = data[IW-1:0];
            REG_FOV_ENABLE:     filter_cfg.fov_en = data[0];
            REG_HALF_FOV_COS:   filter_cfg.cosq   = data[COS_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Release the write port and let the squared thresholds settle
    task automatic end_writes();
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic load_filter_cfg(input t_filter_cfg c);
        write_reg(REG_RANGE_MIN,      CFG_DW'(c.rmin));
        write_reg(REG_RANGE_MAX,      CFG_DW'(c.rmax));
        write_reg(REG_INTENSITY_LOW,  CFG_DW'(c.ilow));
        write_reg(REG_INTENSITY_HIGH, CFG_DW'(c.ihigh));
        write_reg(REG_FOV_ENABLE,     CFG_DW'(c.fov_en));
        write_reg(REG_HALF_FOV_COS,   CFG_DW'($unsigned(c.cosq)));
        end_writes();
    endtask

    //------------------------------------------------------------------------
    // Point source
    //------------------------------------------------------------------------

    function automatic t_point mk_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                        logic signed [CW-1:0] z, logic [IW-1:0] inten,
                                        logic fin, logic last);
        t_point p;
        p.x     = x;
        p.y     = y;
        p.z     = z;
        p.inten = inten;
        p.fin   = fin;
        p.last  = last;
        return p;
    endfunction

    // Offer one point and hold it until the transfer; valid stays high on return so that
    // a back-to-back point follows without a bubble
    task automatic send_point(input t_point p);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            pt_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_in.valid     <= 1'b1;
        pt_in.px        <= p.x;
        pt_in.py        <= p.y;
        pt_in.pz        <= p.z;
        pt_in.intensity <= p.inten;
        pt_in.finite    <= p.fin;
        pt_in.last_in   <= p.last;
        do @(posedge i_clk); while (!pt_in.ready);
        filtered_due.insert(filtered_due.size(), predict_filtered_point(p));
    endtask

    // Drop valid and wait until every predicted point has come out and the pipe is empty
    task automatic close_burst();
        pt_in.valid <= 1'b0;
        while (filtered_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 1) @(posedge i_clk);
    endtask

    //------------------------------------------------------------------------
    // Result sink and checker
    //------------------------------------------------------------------------

    initial begin : result_sink
        int stall;
        pt_out.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall       = (rx_idle ? $urandom_range(0, 16) : 0) + rx_hold_req;
            rx_hold_req = 0;
            if (stall > 0) begin
                pt_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pt_out.ready <= 1'b1;
            do @(posedge i_clk); while (!pt_out.valid);
        end
    end

    always @(posedge i_clk) begin : check_filtered
        t_filtered due;
        if (i_rst_n && pt_out.valid && pt_out.ready) begin
            if (filtered_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected point out: x=%0d y=%0d z=%0d i=%0d keep=%0b last=%0b",
                             pt_out.qx, pt_out.qy, pt_out.qz, pt_out.q_intensity,
                             pt_out.keep, pt_out.last_out);
            end else begin
                due = filtered_due.pop_front();
                if (pt_out.qx !== due.x || pt_out.qy !== due.y || pt_out.qz !== due.z ||
                    pt_out.q_intensity !== due.inten || pt_out.keep !== due.keep ||
                    pt_out.last_out !== due.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected x=%0d y=%0d z=%0d i=%0d keep=%0b last=%0b",
                                 due.x, due.y, due.z, due.inten, due.keep, due.last);
                        $display("  actual   x=%0d y=%0d z=%0d i=%0d keep=%0b last=%0b",
                                 pt_out.qx, pt_out.qy, pt_out.qz, pt_out.q_intensity,
                                 pt_out.keep, pt_out.last_out);
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------------
    // Random stimulus
    //------------------------------------------------------------------------

    function automatic logic signed [CW-1:0] random_coord();
        logic signed [CW-1:0] v;
        int k, d;
        case ($urandom_range(0, 3))
            0: v = CW'($urandom);
            1: begin
                // magnitude of a random bit length, so that every range scale turns up
                k = $urandom_range(1, CW - 2);
                v = CW'($urandom_range(0, (1 << k) - 1));
                if ($urandom_range(0, 1) != 0) v = -v;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: v = CMAX;
                    1: v = CMIN;
                    2: v = '0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            default: begin
                d = $urandom_range(0, 200);
                v = CW'(d - 100);
            end
        endcase
        return v;
    endfunction

    function automatic t_point random_point();
        t_point p;
        int base, d;
        p.x = random_coord();
        p.y = random_coord();
        p.z = random_coord();
        // now and then put a point on the x axis within two of a range threshold
        if ($urandom_range(0, 5) == 0) begin
            base = ($urandom_range(0, 1) != 0) ? int'(filter_cfg.rmin) : int'(filter_cfg.rmax);
            d    = $urandom_range(0, 4);
            base = base + d - 2;
            if (base >= 0 && base <= int'(CMAX)) begin
                p.x = ($urandom_range(0, 1) != 0) ? CW'(base) : CW'(-base);
                p.y = '0;
                p.z = '0;
            end
        end
        if ($urandom_range(0, 1) != 0) begin
            p.inten = IW'($urandom);
        end else begin
            base    = ($urandom_range(0, 1) != 0) ? int'(filter_cfg.ilow) : int'(filter_cfg.ihigh);
            d       = $urandom_range(0, 2);
            p.inten = IW'(base + d - 1);
        end
        p.fin  = ($urandom_range(0, 9) != 0);
        p.last = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    // The first phases pin the register extremes, the rest draw settings at random
    function automatic t_filter_cfg random_filter_cfg(int phase);
        t_filter_cfg c;
        logic [CW-1:0] swap;
        c = reset_filter_cfg();
        case (phase)
            0: begin
                c.fov_en = 1'b1;
                c.cosq   = {1'b0, {(COS_WIDTH-1){1'b1}}};
            end
            1: begin
                c.rmin  = '1;
                c.ilow  = '1;
            end
            2: begin
                c.rmax   = '0;
                c.ihigh  = '0;
                c.fov_en = 1'b1;
            end
            default: begin
                c.rmin   = CW'($urandom_range(0, 1 << (CW - 2)));
                c.rmax   = c.rmin + CW'($urandom_range(0, 1 << (CW - 1)));
                c.ilow   = IW'($urandom_range(0, 40000));
                c.ihigh  = c.ilow + IW'($urandom_range(0, 25535));
                c.fov_en = 1'($urandom_range(0, 1));
                c.cosq   = COS_WIDTH'($urandom);
                if ($urandom_range(0, 7) == 0) begin
                    swap   = c.rmin;
                    c.rmin = c.rmax;
                    c.rmax = swap;
                end
            end
        endcase
        return c;
    endfunction

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    // Registers straight out of reset: extremes of every field pass, a non-finite point drops
    task automatic test_reset_defaults();
        send_point(mk_point(CMAX, CMAX, CMAX, '1, 1'b1, 1'b0));
        send_point(mk_point(CMIN, CMIN, CMIN, '0, 1'b1, 1'b1));
        send_point(mk_point('0, '0, '0, '0, 1'b1, 1'b0));
        send_point(mk_point(CMAX, '0, CMIN, 16'h8000, 1'b0, 1'b1));
        close_burst();
    endtask

    // Range window edges, including a window that is turned inside out
    task automatic test_range_window();
        t_filter_cfg c;
        c      = reset_filter_cfg();
        c.rmin = 1000;
        c.rmax = 2000;
        load_filter_cfg(c);
        send_point(mk_point(1000, 0, 0, 16'd5, 1'b1, 1'b0));
        send_point(mk_point(-999, 0, 0, 16'd5, 1'b1, 1'b0));
        send_point(mk_point(0, 2000, 0, 16'd5, 1'b1, 1'b0));
        send_point(mk_point(0, 0, -2001, 16'd5, 1'b1, 1'b0));
        send_point(mk_point(600, -800, 0, 16'd5, 1'b1, 1'b1));
        close_burst();
        c.rmin = 2000;
        c.rmax = 1000;
        load_filter_cfg(c);
        send_point(mk_point(1500, 0, 0, 16'd5, 1'b1, 1'b1));
        close_burst();
    endtask

    // Intensity band edges, then an empty band
    task automatic test_intensity_band();
        t_filter_cfg c;
        c       = reset_filter_cfg();
        c.ilow  = 100;
        c.ihigh = 200;
        load_filter_cfg(c);
        send_point(mk_point(10, 10, 10, 16'd99, 1'b1, 1'b0));
        send_point(mk_point(10, 10, 10, 16'd100, 1'b1, 1'b0));
        send_point(mk_point(10, 10, 10, 16'd200, 1'b1, 1'b0));
        send_point(mk_point(10, 10, 10, 16'd201, 1'b1, 1'b1));
        close_burst();
        c.ilow  = 200;
        c.ihigh = 100;
        load_filter_cfg(c);
        send_point(mk_point(10, 10, 10, 16'd150, 1'b1, 1'b1));
        close_burst();
    endtask

    // Azimuth window: full circle, origin, a 90 degree window, zero cosine, obtuse window
    task automatic test_azimuth_window();
        t_filter_cfg c;
        c        = reset_filter_cfg();
        c.fov_en = 1'b1;
        load_filter_cfg(c);
        send_point(mk_point(-5, 0, 7, 16'd1, 1'b1, 1'b0));
        send_point(mk_point(0, 0, 9, 16'd1, 1'b1, 1'b0));
        send_point(mk_point(-5, 1, 0, 16'd1, 1'b1, 1'b1));
        close_burst();
        c.cosq = 16'sd23170;
        load_filter_cfg(c);
        send_point(mk_point(100, 100, 0, 16'd1, 1'b1, 1'b0));
        send_point(mk_point(100, 101, 0, 16'd1, 1'b1, 1'b0));
        send_point(mk_point(-1, 0, 0, 16'd1, 1'b1, 1'b1));
        close_burst();
        c.cosq = 16'sd0;
        load_filter_cfg(c);
        send_point(mk_point(0, 5, 0, 16'd1, 1'b1, 1'b1));
        close_burst();
        c.cosq = -16'sd16384;
        load_filter_cfg(c);
        send_point(mk_point(-1, 5, 0, 16'd1, 1'b1, 1'b0));
        send_point(mk_point(-5, 1, 0, 16'd1, 1'b1, 1'b1));
        close_burst();
    endtask

    // Upper write-data bits beyond a register's width are dropped, spare indexes do nothing
    task automatic test_register_masking();
        load_filter_cfg(reset_filter_cfg());
        write_reg(REG_INTENSITY_LOW, 24'hFF0010);
        write_reg(REG_FOV_ENABLE,    24'h000002);
        write_reg(REG_HALF_FOV_COS,  24'hAB8000);
        write_reg(REG_SPARE_A,       24'h00FFFF);
        write_reg(REG_SPARE_B,       24'hFFFFFF);
        end_writes();
        send_point(mk_point(3, 4, 0, 16'h000F, 1'b1, 1'b0));
        send_point(mk_point(3, 4, 0, 16'h0010, 1'b1, 1'b0));
        send_point(mk_point(-5, 0, 0, 16'h0010, 1'b1, 1'b1));
        close_burst();
    endtask

    // Hold the result side off for a long stretch while points keep coming, so the pipe fills
    // and stalls its input; then pause the source until everything has drained, and run two more bursts
    task automatic test_backpressure();
        load_filter_cfg(random_filter_cfg(3));
        tx_idle     = 1'b0;
        rx_idle     = 1'b0;
        rx_hold_req = 200;
        repeat (40) send_point(random_point());
        close_burst();
        rx_idle = 1'b1;
        repeat (20) send_point(random_point());
        close_burst();
        repeat (20) send_point(random_point());
        close_burst();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 9; phase++) begin
            load_filter_cfg(random_filter_cfg(phase));
            // vary which side idles, with one phase in four running flat out
            tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
            rx_idle = (phase % 4 == 0) || (phase % 4 == 1);
            repeat (190) send_point(random_point());
            close_burst();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    //------------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------------

    initial begin
        filter_cfg         = reset_filter_cfg();
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        pt_in.valid        = 1'b0;
        pt_in.px           = '0;
        pt_in.py           = '0;
        pt_in.pz           = '0;
        pt_in.intensity    = '0;
        pt_in.finite       = 1'b0;
        pt_in.last_in      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_range_window();
        test_intensity_band();
        test_azimuth_window();
        test_register_masking();
        test_backpressure();
        test_random_phases();

        // catch any stray point after the last expected one
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        if (mismatch_count == 0 && filtered_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
